// File: hw/rtl/signed_decimal_formatter_core_macros.svh
// Assertion macros shared by the signed decimal formatter checker.
`ifndef SIGNED_DECIMAL_FORMATTER_CORE_MACROS_SVH
`define SIGNED_DECIMAL_FORMATTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled in reset.
`define SDF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled in reset.
`define SDF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/sdf_pkg.sv
// Types and constants of the signed decimal formatter.
package sdf_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int WIDTH_BITS     = 6;
   localparam int CHAR_BITS      = 7;
   localparam int DIGITS         = 10;
   localparam int DIGIT_IDX_BITS = $clog2(DIGITS);
   localparam int STEP_BITS      = $clog2(VALUE_BITS);
   localparam int MAX_WIDTH      = 63;

   localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 7'h2B;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 7'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 7'h20;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [WIDTH_BITS-1:0]        field_width;
      logic                         left_justify;
      logic                         zero_pad;
      logic                         force_plus;
   } sdf_req_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] character;
      logic                 last;
   } sdf_rsp_type;

   typedef struct packed {
      logic                  neg;
      logic                  has_sign;
      logic                  left;
      logic                  zpad;
      logic [WIDTH_BITS-1:0] width;
   } sdf_fmt_type;

   typedef struct packed {
      logic                  start;
      logic [VALUE_BITS-1:0] mag;
   } sdf_conv_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sdf_conv_sts_type;

   typedef logic [DIGITS-1:0][3:0] sdf_bcd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_LEAD,
      ST_SIGN,
      ST_ZERO,
      ST_DIGIT,
      ST_TRAIL
   } sdf_state_type;

endpackage

// File: hw/rtl/sdf_bcd_conv.sv
// Iterative binary to decimal converter, one shift-and-adjust step per cycle.
module sdf_bcd_conv (
   input  logic                     clock,
   input  logic                     reset,
   input  sdf_pkg::sdf_conv_ctl_type ctl,
   output sdf_pkg::sdf_conv_sts_type sts,
   output sdf_pkg::sdf_bcd_type      digits
);
   import sdf_pkg::*;

   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [DIGITS*4-1:0]   bcd_ff, bcd_in;
   logic [DIGITS*4-1:0]   adj;
   logic [STEP_BITS-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  last_step;

   assign last_step = (cnt_ff == STEP_BITS'(VALUE_BITS - 1));

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         bin_in  = ctl.mag;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bin_in  = {bin_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in  = {adj[DIGITS*4-2:0], bin_ff[VALUE_BITS-1]};
         cnt_in  = cnt_ff + 1'b1;
         busy_in = !last_step;
         done_in = last_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign digits   = sdf_bcd_type'(bcd_ff);

endmodule

// File: hw/rtl/sdf_emitter.sv
// Character sequencer that emits padding, sign and digits one item per cycle while the output is not stalled.
module sdf_emitter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  sdf_pkg::sdf_fmt_type      fmt,
   input  sdf_pkg::sdf_conv_sts_type conv_sts,
   input  sdf_pkg::sdf_bcd_type      digits,
   output logic                      busy,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sdf_pkg::sdf_rsp_type      rsp_payload
);
   import sdf_pkg::*;

   sdf_state_type             state_ff, state_in;
   logic [WIDTH_BITS-1:0]     pad_ff, pad_in;
   logic [DIGIT_IDX_BITS-1:0] dig_ff, dig_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   sdf_rsp_type               rsp_ff, rsp_in;

   logic [DIGIT_IDX_BITS:0]   nd;
   logic [WIDTH_BITS-1:0]     body;
   logic [WIDTH_BITS-1:0]     pad_calc;
   logic                      out_free;
   logic                      lead_mode;
   logic                      zero_mode;
   logic                      load;
   logic                      emit;
   logic                      pad_dec;
   logic                      dig_dec;
   logic                      last;
   logic [CHAR_BITS-1:0]      ch;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign lead_mode = !fmt.left && !fmt.zpad;
   assign zero_mode = !fmt.left && fmt.zpad;

   always_comb begin
      nd = (DIGIT_IDX_BITS+1)'(1);
      for (int i = 1; i < DIGITS; i++) begin
         if (digits[i] != 4'd0) begin
            nd = (DIGIT_IDX_BITS+1)'(i + 1);
         end
      end
   end

   assign body     = WIDTH_BITS'(nd) + WIDTH_BITS'(fmt.has_sign);
   assign pad_calc = (fmt.width > body) ? (fmt.width - body) : '0;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_sts.done) begin
               if (lead_mode && pad_calc != '0) begin
                  state_in = ST_LEAD;
               end else if (fmt.has_sign) begin
                  state_in = ST_SIGN;
               end else if (zero_mode && pad_calc != '0) begin
                  state_in = ST_ZERO;
               end else begin
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_LEAD: begin
            if (out_free && pad_ff == WIDTH_BITS'(1)) begin
               state_in = fmt.has_sign ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = (zero_mode && pad_ff != '0) ? ST_ZERO : ST_DIGIT;
            end
         end
         ST_ZERO: begin
            if (out_free && pad_ff == WIDTH_BITS'(1)) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free && dig_ff == '0) begin
               state_in = (fmt.left && pad_ff != '0) ? ST_TRAIL : ST_IDLE;
            end
         end
         ST_TRAIL: begin
            if (out_free && pad_ff == WIDTH_BITS'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      load    = 1'b0;
      emit    = 1'b0;
      pad_dec = 1'b0;
      dig_dec = 1'b0;
      last    = 1'b0;
      ch      = CHAR_SPACE;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_CONV: begin
            load = conv_sts.done;
         end
         ST_LEAD: begin
            emit    = out_free;
            pad_dec = out_free;
         end
         ST_SIGN: begin
            emit = out_free;
            ch   = fmt.neg ? CHAR_MINUS : CHAR_PLUS;
         end
         ST_ZERO: begin
            emit    = out_free;
            pad_dec = out_free;
            ch      = CHAR_ZERO;
         end
         ST_DIGIT: begin
            emit    = out_free;
            dig_dec = out_free;
            ch      = CHAR_ZERO + CHAR_BITS'(digits[dig_ff]);
            last    = (dig_ff == '0) && !(fmt.left && pad_ff != '0);
         end
         ST_TRAIL: begin
            emit    = out_free;
            pad_dec = out_free;
            last    = (pad_ff == WIDTH_BITS'(1));
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      pad_in = pad_ff;
      dig_in = dig_ff;
      if (load) begin
         pad_in = pad_calc;
         dig_in = DIGIT_IDX_BITS'(nd - 1'b1);
      end else begin
         if (pad_dec) begin
            pad_in = pad_ff - 1'b1;
         end
         if (dig_dec && dig_ff != '0) begin
            dig_in = dig_ff - 1'b1;
         end
      end
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_in.character = ch;
         rsp_in.last      = last;
         rsp_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pad_ff <= pad_in;
      dig_ff <= dig_in;
      rsp_ff <= rsp_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: hw/rtl/signed_decimal_formatter_core.sv
// Signed decimal formatter: prints a 32-bit value as printf %d text, one character per item.
// The first character is registered after the conversion and the sequencer's load step.
// The binary to decimal converter shifts in one bit per cycle, then the sequencer loads its counts.
// The block takes no new item until it has emitted the last character of the current one.
// Reset is synchronous and active high; it empties the sequencer and the output register.
module signed_decimal_formatter_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sdf_pkg::sdf_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sdf_pkg::sdf_rsp_type rsp_payload
);
   import sdf_pkg::*;

   logic                  accept;
   logic                  busy;
   logic                  neg;
   logic [VALUE_BITS-1:0] raw;
   logic [WIDTH_BITS-1:0] width_sat;
   sdf_fmt_type           fmt_ff, fmt_in;
   sdf_conv_ctl_type      conv_ctl;
   sdf_conv_sts_type      conv_sts;
   sdf_bcd_type           digits;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign raw       = req_payload.value;
   assign neg       = raw[VALUE_BITS-1];

   assign width_sat = (req_payload.field_width > WIDTH_BITS'(MAX_WIDTH)) ?
                      WIDTH_BITS'(MAX_WIDTH) : req_payload.field_width;

   assign conv_ctl.start = accept;
   assign conv_ctl.mag   = neg ? (VALUE_BITS'(0) - raw) : raw;

   always_comb begin
      fmt_in = fmt_ff;
      if (accept) begin
         fmt_in.neg      = neg;
         fmt_in.has_sign = neg || req_payload.force_plus;
         fmt_in.left     = req_payload.left_justify;
         fmt_in.zpad     = req_payload.zero_pad;
         fmt_in.width    = width_sat;
      end
   end

   always_ff @(posedge clock) begin
      fmt_ff <= fmt_in;
   end

   sdf_bcd_conv u_conv (
      .clock  (clock),
      .reset  (reset),
      .ctl    (conv_ctl),
      .sts    (conv_sts),
      .digits (digits)
   );

   sdf_emitter u_emit (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .fmt         (fmt_ff),
      .conv_sts    (conv_sts),
      .digits      (digits),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: hw/rtl/sdf_checker.sv
// Port-level checker for the signed decimal formatter and its bind statement.
`include "signed_decimal_formatter_core_macros.svh"

module sdf_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input sdf_pkg::sdf_rsp_type rsp_payload
);
   import sdf_pkg::*;

   logic req_fire;
   logic rsp_held;
   logic rsp_idle;
   logic char_ok;

   assign req_fire = req_valid && !req_stall;
   assign rsp_held = rsp_valid && rsp_stall;
   assign rsp_idle = rsp_valid && !req_stall;
   assign char_ok  = (rsp_payload.character == CHAR_SPACE) ||
                     (rsp_payload.character == CHAR_PLUS) ||
                     (rsp_payload.character == CHAR_MINUS) ||
                     (rsp_payload.character >= CHAR_ZERO &&
                      rsp_payload.character <= CHAR_NINE);

   `SDF_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_payload), "Held item changed.")

   `SDF_ASSERT_NEXT(a_busy_after_accept, req_fire, req_stall, "Block took a second item.")

   `SDF_ASSERT_NOW(a_idle_only_last, rsp_idle, rsp_payload.last, "Idle before the final character.")

   `SDF_ASSERT_NOW(a_char_set, rsp_valid, char_ok, "Character outside the expected set.")

endmodule

bind signed_decimal_formatter_core sdf_checker u_sdf_checker (.*);
